// ===== design/gcns_pkg.sv =====
// ----------------------------------------------------------------------------
// gcns_pkg
// Shared widths, codes and helper functions of the grid cell
// neighbor search block.
// ----------------------------------------------------------------------------
package gcns_pkg;

  localparam int POS_W     = 32;
  localparam int INV_W     = 31;
  localparam int DIM_W     = 13;
  localparam int COORD_W   = 12;
  localparam int EXT_W     = 25;
  localparam int NBR_W     = 10;
  localparam int ACT_W     = 2;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int DIM_LIMIT = 4096;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 31;
  localparam int MUL_P_W = 48;

  localparam int DEF_MAX_POINTS     = 1024;
  localparam int DEF_MAX_CELLS      = 4096;
  localparam int DEF_MAX_CANDIDATES = 64;

  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [2:0] REG_MIN_X  = 3'd0;
  localparam logic [2:0] REG_MIN_Y  = 3'd1;
  localparam logic [2:0] REG_MIN_Z  = 3'd2;
  localparam logic [2:0] REG_INV    = 3'd3;
  localparam logic [2:0] REG_CELLS_X = 3'd4;
  localparam logic [2:0] REG_CELLS_Y = 3'd5;
  localparam logic [2:0] REG_CELLS_Z = 3'd6;
  localparam logic [2:0] REG_EXTENT = 3'd7;

  // A cell count of zero acts as one, and one above the limit as the limit.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(DIM_LIMIT)) begin
      r = DIM_W'(DIM_LIMIT);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [POS_W-1:0] v,
                                                     input logic [DIM_W-1:0] d);
    logic [COORD_W-1:0] r;
    if (v >= POS_W'(d)) begin
      r = COORD_W'(d - DIM_W'(1));
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/gcns_req_if.sv =====
// ----------------------------------------------------------------------------
// gcns_req_if
// Request channel: one item is a load, a query or a clear.
// ----------------------------------------------------------------------------
interface gcns_req_if;
  logic                              valid;
  logic                              ready;
  logic [gcns_pkg::ACT_W-1:0]        action;
  logic signed [gcns_pkg::POS_W-1:0] pos_x;
  logic signed [gcns_pkg::POS_W-1:0] pos_y;
  logic signed [gcns_pkg::POS_W-1:0] pos_z;

  modport source(output valid, action, pos_x, pos_y, pos_z, input ready);
  modport sink(input valid, action, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== design/gcns_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gcns_rsp_if
// Response channel: one item is one candidate of a query.
// ----------------------------------------------------------------------------
interface gcns_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [gcns_pkg::NBR_W-1:0] neighbor_index;
  logic                       found;
  logic                       last;
  logic                       overflow;

  modport source(output valid, neighbor_index, found, last, overflow, input ready);
  modport sink(input valid, neighbor_index, found, last, overflow, output ready);
endinterface

// ===== design/gcns_ram.sv =====
// ----------------------------------------------------------------------------
// gcns_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gcns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/gcns_mul.sv =====
// ----------------------------------------------------------------------------
// gcns_mul
// Shared unsigned multiplier with a registered product. It serves the
// position scaling, in two partial products, and the cell hash terms.
// ----------------------------------------------------------------------------
module gcns_mul (
  input  logic                           clk,
  input  logic [gcns_pkg::MUL_A_W-1:0]   a,
  input  logic [gcns_pkg::MUL_B_W-1:0]   b,
  output logic [gcns_pkg::MUL_P_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= gcns_pkg::MUL_P_W'(a) * gcns_pkg::MUL_P_W'(b);
  end

endmodule

// ===== design/grid_cell_neighbor_search.sv =====
// ----------------------------------------------------------------------------
// grid_cell_neighbor_search
// Uniform 3D grid neighbor search over loaded points, one shared multiplier
// under a sequencer.
// ----------------------------------------------------------------------------
// Usage: items arrive on the request channel (valid/ready). A load bins one
// point into the grid; a clear empties the store.
// A query returns its candidates on the response channel, one item each, the
// final one marked last; a query with no candidate returns one not-found item.
// The first query after a load or clear first rebuilds the cell table: it
// zeroes the table, counts the points per cell, forms the prefix sum and
// scatters the points. The query itself computes the cell box, walks the
// cells in the box and buffers each candidate, then returns the results
// while the receiver takes them. The shared multiplier and the single port
// of the cell table keep these steps sequential. The block takes one item
// at a time: ready is high only while idle, and a stalled receiver holds
// the block until the last result is taken. Registers are to be written
// over the APB port while the block is idle; the block does not enforce
// this. Reset empties the store and restores the register defaults.
// ----------------------------------------------------------------------------
module grid_cell_neighbor_search #(
  parameter int MAX_POINTS     = gcns_pkg::DEF_MAX_POINTS,
  parameter int MAX_CELLS      = gcns_pkg::DEF_MAX_CELLS,
  parameter int MAX_CANDIDATES = gcns_pkg::DEF_MAX_CANDIDATES
) (
  input  logic                          clk,
  input  logic                          rst,
  gcns_req_if.sink                      request,
  gcns_rsp_if.source                    response,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcns_pkg::CFG_AW-1:0]   paddr,
  input  logic [gcns_pkg::CFG_DW-1:0]   pwdata,
  output logic [gcns_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int PIW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PCW  = $clog2(MAX_POINTS + 1);
  localparam int CW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CSAW = $clog2(MAX_CELLS + 1);
  localparam int BW   = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int NW   = $clog2(MAX_CANDIDATES + 1);
  localparam int PW   = gcns_pkg::MUL_P_W;
  localparam int XW   = gcns_pkg::COORD_W;

  typedef enum logic [28:0] {
    IDLE   = 29'd1 << 0,
    B_CLR  = 29'd1 << 1,
    B_C0   = 29'd1 << 2,
    B_C1   = 29'd1 << 3,
    B_C2   = 29'd1 << 4,
    B_P0   = 29'd1 << 5,
    B_P1   = 29'd1 << 6,
    B_PEND = 29'd1 << 7,
    B_S0   = 29'd1 << 8,
    B_S1   = 29'd1 << 9,
    B_S2   = 29'd1 << 10,
    S_MLO  = 29'd1 << 11,
    S_MHI  = 29'd1 << 12,
    S_SUM  = 29'd1 << 13,
    S_EDGE = 29'd1 << 14,
    H_CXY  = 29'd1 << 15,
    H_CC   = 29'd1 << 16,
    H_Y    = 29'd1 << 17,
    H_Z    = 29'd1 << 18,
    H_SUM  = 29'd1 << 19,
    L_WR   = 29'd1 << 20,
    W_RD0  = 29'd1 << 21,
    W_RD1  = 29'd1 << 22,
    W_RD2  = 29'd1 << 23,
    W_PT   = 29'd1 << 24,
    W_WR   = 29'd1 << 25,
    E_RD   = 29'd1 << 26,
    E_LD   = 29'd1 << 27,
    E_WAIT = 29'd1 << 28
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [gcns_pkg::POS_W-1:0] min_x, min_y, min_z;
  logic [gcns_pkg::INV_W-1:0]        inv_cell_size;
  logic [gcns_pkg::DIM_W-1:0]        cells_x, cells_y, cells_z;
  logic [gcns_pkg::EXT_W-1:0]        search_extent;

  // Control and datapath registers.
  logic [PCW-1:0]  count, bi, k, kend, psum;
  logic            built, is_query, over;
  logic [CSAW-1:0] bc;
  logic [CW-1:0]   bcell, hash;
  logic [1:0]      ax;
  logic signed [gcns_pkg::POS_W-1:0] px, py, pz;
  logic [46:0]     acc;
  logic [63:0]     m;
  logic [XW-1:0]   lo [3];
  logic [XW-1:0]   hi [3];
  logic [XW-1:0]   cur_x, cur_y, cur_z;
  logic [24:0]     cxcy, hacc;
  logic [NW-1:0]   n;
  logic [BW-1:0]   j;
  logic            o_valid, o_found, o_last, o_ov;
  logic [gcns_pkg::NBR_W-1:0] o_idx;

  // Shared multiplier.
  logic [gcns_pkg::MUL_A_W-1:0] mul_a;
  logic [gcns_pkg::MUL_B_W-1:0] mul_b;
  logic [PW-1:0]                p;

  // Memory ports.
  logic            pc_we, cs_we, sp_we, cb_we;
  logic [PIW-1:0]  pc_waddr, pc_raddr, sp_waddr, sp_raddr;
  logic [CW-1:0]   pc_wdata, pc_rdata;
  logic [CSAW-1:0] cs_waddr, cs_raddr;
  logic [PCW-1:0]  cs_wdata, cs_rdata;
  logic [PIW-1:0]  sp_wdata, sp_rdata;
  logic [BW-1:0]   cb_waddr, cb_raddr;
  logic [gcns_pkg::NBR_W-1:0] cb_wdata, cb_rdata;

  // ---------------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x         <= '0;
      min_y         <= '0;
      min_z         <= '0;
      inv_cell_size <= gcns_pkg::INV_W'(65536);
      cells_x       <= gcns_pkg::DIM_W'(1);
      cells_y       <= gcns_pkg::DIM_W'(1);
      cells_z       <= gcns_pkg::DIM_W'(1);
      search_extent <= gcns_pkg::EXT_W'(65536);
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        gcns_pkg::REG_MIN_X:   min_x <= pwdata;
        gcns_pkg::REG_MIN_Y:   min_y <= pwdata;
        gcns_pkg::REG_MIN_Z:   min_z <= pwdata;
        gcns_pkg::REG_INV:     inv_cell_size <= pwdata[gcns_pkg::INV_W-1:0];
        gcns_pkg::REG_CELLS_X: cells_x <= pwdata[gcns_pkg::DIM_W-1:0];
        gcns_pkg::REG_CELLS_Y: cells_y <= pwdata[gcns_pkg::DIM_W-1:0];
        gcns_pkg::REG_CELLS_Z: cells_z <= pwdata[gcns_pkg::DIM_W-1:0];
        gcns_pkg::REG_EXTENT:  search_extent <= pwdata[gcns_pkg::EXT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      gcns_pkg::REG_MIN_X:   prdata = min_x;
      gcns_pkg::REG_MIN_Y:   prdata = min_y;
      gcns_pkg::REG_MIN_Z:   prdata = min_z;
      gcns_pkg::REG_INV:     prdata = gcns_pkg::CFG_DW'(inv_cell_size);
      gcns_pkg::REG_CELLS_X: prdata = gcns_pkg::CFG_DW'(cells_x);
      gcns_pkg::REG_CELLS_Y: prdata = gcns_pkg::CFG_DW'(cells_y);
      gcns_pkg::REG_CELLS_Z: prdata = gcns_pkg::CFG_DW'(cells_z);
      gcns_pkg::REG_EXTENT:  prdata = gcns_pkg::CFG_DW'(search_extent);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Per axis cell span.
  // ---------------------------------------------------------------------------
  logic [gcns_pkg::DIM_W-1:0] cx_eff, cy_eff, cz_eff, dim_sel;
  logic signed [gcns_pkg::POS_W-1:0] pos_sel, min_sel;
  logic [32:0]   diff, mag;
  logic          neg;
  logic [63:0]   ext64, sum_pe, diff_me, diff_em;
  logic          m_ge_e;
  logic [XW-1:0] lo_v, hi_v;

  assign cx_eff = gcns_pkg::eff_dim(cells_x);
  assign cy_eff = gcns_pkg::eff_dim(cells_y);
  assign cz_eff = gcns_pkg::eff_dim(cells_z);

  always_comb begin
    case (ax)
      2'd0: begin
        pos_sel = px;
        min_sel = min_x;
        dim_sel = cx_eff;
      end
      2'd1: begin
        pos_sel = py;
        min_sel = min_y;
        dim_sel = cy_eff;
      end
      default: begin
        pos_sel = pz;
        min_sel = min_z;
        dim_sel = cz_eff;
      end
    endcase
  end

  assign diff = {pos_sel[31], pos_sel} - {min_sel[31], min_sel};
  assign neg  = diff[32];
  assign mag  = neg ? (33'd0 - diff) : diff;

  // A load bins the point itself, so its extent is zero.
  assign ext64   = is_query ? {23'd0, search_extent, 16'd0} : 64'd0;
  assign sum_pe  = m + ext64;
  assign diff_me = m - ext64;
  assign diff_em = ext64 - m;
  assign m_ge_e  = (m >= ext64);

  always_comb begin
    if (neg) begin
      lo_v = '0;
      hi_v = m_ge_e ? '0 : gcns_pkg::clamp_coord(diff_em[63:32], dim_sel);
    end else begin
      lo_v = m_ge_e ? gcns_pkg::clamp_coord(diff_me[63:32], dim_sel) : '0;
      hi_v = gcns_pkg::clamp_coord(sum_pe[63:32], dim_sel);
    end
  end

  // Cell hash, saturated at the last entry of the table.
  logic [PW-1:0] hsum;
  logic [CW-1:0] hash_v;
  assign hsum   = PW'(hacc) + p + PW'(cur_x);
  assign hash_v = (hsum >= PW'(MAX_CELLS)) ? CW'(MAX_CELLS - 1) : hsum[CW-1:0];

  logic [PCW-1:0] bi_m1;
  logic           last_cell, has_pt;
  assign bi_m1     = bi - PCW'(1);
  assign last_cell = (cur_x == hi[0]) && (cur_y == hi[1]) && (cur_z == hi[2]);
  assign has_pt    = (k < kend);

  // ---------------------------------------------------------------------------
  // Multiplier operands and memory controls.
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    pc_we    = 1'b0;
    pc_waddr = count[PIW-1:0];
    pc_wdata = hash;
    pc_raddr = bi[PIW-1:0];
    cs_we    = 1'b0;
    cs_waddr = bc;
    cs_wdata = '0;
    cs_raddr = bc;
    sp_we    = 1'b0;
    sp_waddr = '0;
    sp_wdata = bi_m1[PIW-1:0];
    sp_raddr = k[PIW-1:0];
    cb_we    = 1'b0;
    cb_waddr = n[BW-1:0];
    cb_wdata = gcns_pkg::NBR_W'(sp_rdata);
    cb_raddr = j;
    unique case (state)
      B_CLR: begin
        cs_we = 1'b1;
      end
      B_C1, B_S1: begin
        cs_raddr = CSAW'(pc_rdata);
      end
      B_C2: begin
        cs_we    = 1'b1;
        cs_waddr = CSAW'(bcell);
        cs_wdata = cs_rdata + PCW'(1);
      end
      B_P1: begin
        cs_we    = 1'b1;
        cs_wdata = psum + cs_rdata;
      end
      B_PEND: begin
        cs_we    = 1'b1;
        cs_waddr = CSAW'(MAX_CELLS);
        cs_wdata = count;
      end
      B_S0: begin
        pc_raddr = bi_m1[PIW-1:0];
      end
      B_S2: begin
        // Scatter from the last point down, so each cell stays in load order.
        cs_we    = 1'b1;
        cs_waddr = CSAW'(bcell);
        cs_wdata = cs_rdata - PCW'(1);
        sp_we    = 1'b1;
        sp_waddr = cs_wdata[PIW-1:0];
      end
      S_MLO: begin
        mul_a = {1'b0, mag[15:0]};
        mul_b = inv_cell_size;
      end
      S_MHI: begin
        mul_a = mag[32:16];
        mul_b = inv_cell_size;
      end
      H_CXY: begin
        mul_a = gcns_pkg::MUL_A_W'(cx_eff);
        mul_b = gcns_pkg::MUL_B_W'(cy_eff);
      end
      H_Y: begin
        mul_a = gcns_pkg::MUL_A_W'(cur_y);
        mul_b = gcns_pkg::MUL_B_W'(cx_eff);
      end
      H_Z: begin
        mul_a = gcns_pkg::MUL_A_W'(cur_z);
        mul_b = gcns_pkg::MUL_B_W'(cxcy);
      end
      L_WR: begin
        pc_we = 1'b1;
      end
      W_RD0: begin
        cs_raddr = CSAW'(hash);
      end
      W_RD1: begin
        cs_raddr = CSAW'(hash) + CSAW'(1);
      end
      W_WR: begin
        cb_we = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  assign request.ready           = (state == IDLE);
  assign response.valid          = o_valid;
  assign response.neighbor_index = o_idx;
  assign response.found          = o_found;
  assign response.last           = o_last;
  assign response.overflow       = o_ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      count   <= '0;
      built   <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (request.valid) begin
            px   <= request.pos_x;
            py   <= request.pos_y;
            pz   <= request.pos_z;
            n    <= '0;
            over <= 1'b0;
            ax   <= '0;
            case (request.action)
              gcns_pkg::ACT_LOAD: begin
                built    <= 1'b0;
                is_query <= 1'b0;
                if (count < PCW'(MAX_POINTS)) begin
                  state <= S_MLO;
                end
              end
              gcns_pkg::ACT_QUERY: begin
                is_query <= 1'b1;
                bc       <= '0;
                state    <= built ? S_MLO : B_CLR;
              end
              gcns_pkg::ACT_CLEAR: begin
                count <= '0;
                built <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        B_CLR: begin
          if (bc == CSAW'(MAX_CELLS)) begin
            bi    <= '0;
            state <= B_C0;
          end else begin
            bc <= bc + CSAW'(1);
          end
        end
        B_C0: begin
          if (bi == count) begin
            bc    <= '0;
            psum  <= '0;
            state <= B_P0;
          end else begin
            state <= B_C1;
          end
        end
        B_C1: begin
          bcell <= pc_rdata;
          state <= B_C2;
        end
        B_C2: begin
          bi    <= bi + PCW'(1);
          state <= B_C0;
        end
        B_P0: begin
          state <= B_P1;
        end
        B_P1: begin
          psum <= psum + cs_rdata;
          if (bc == CSAW'(MAX_CELLS - 1)) begin
            state <= B_PEND;
          end else begin
            bc    <= bc + CSAW'(1);
            state <= B_P0;
          end
        end
        B_PEND: begin
          bi    <= count;
          state <= B_S0;
        end
        B_S0: begin
          if (bi == '0) begin
            built <= 1'b1;
            state <= S_MLO;
          end else begin
            state <= B_S1;
          end
        end
        B_S1: begin
          bcell <= pc_rdata;
          state <= B_S2;
        end
        B_S2: begin
          bi    <= bi_m1;
          state <= B_S0;
        end
        S_MLO: begin
          state <= S_MHI;
        end
        S_MHI: begin
          acc   <= p[46:0];
          state <= S_SUM;
        end
        S_SUM: begin
          m     <= 64'(acc) + {p, 16'd0};
          state <= S_EDGE;
        end
        S_EDGE: begin
          lo[ax] <= lo_v;
          hi[ax] <= hi_v;
          if (ax == 2'd2) begin
            state <= H_CXY;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_MLO;
          end
        end
        H_CXY: begin
          cur_x <= lo[0];
          cur_y <= lo[1];
          cur_z <= lo[2];
          state <= H_CC;
        end
        H_CC: begin
          cxcy  <= p[24:0];
          state <= H_Y;
        end
        H_Y: begin
          state <= H_Z;
        end
        H_Z: begin
          hacc  <= p[24:0];
          state <= H_SUM;
        end
        H_SUM: begin
          hash  <= hash_v;
          state <= is_query ? W_RD0 : L_WR;
        end
        L_WR: begin
          count <= count + PCW'(1);
          state <= IDLE;
        end
        W_RD0: begin
          state <= W_RD1;
        end
        W_RD1: begin
          k     <= cs_rdata;
          state <= W_RD2;
        end
        W_RD2: begin
          kend  <= cs_rdata;
          state <= W_PT;
        end
        W_PT: begin
          if (has_pt && (n != NW'(MAX_CANDIDATES))) begin
            k     <= k + PCW'(1);
            state <= W_WR;
          end else if (has_pt || last_cell) begin
            // A candidate beyond the limit stops the walk with overflow.
            over <= has_pt;
            if (n == '0) begin
              o_idx   <= '0;
              o_found <= 1'b0;
              o_last  <= 1'b1;
              o_ov    <= 1'b0;
              o_valid <= 1'b1;
              state   <= E_WAIT;
            end else begin
              j     <= '0;
              state <= E_RD;
            end
          end else begin
            state <= H_Y;
            if (cur_x != hi[0]) begin
              cur_x <= cur_x + XW'(1);
            end else if (cur_y != hi[1]) begin
              cur_x <= lo[0];
              cur_y <= cur_y + XW'(1);
            end else begin
              cur_x <= lo[0];
              cur_y <= lo[1];
              cur_z <= cur_z + XW'(1);
            end
          end
        end
        W_WR: begin
          n     <= n + NW'(1);
          state <= W_PT;
        end
        E_RD: begin
          state <= E_LD;
        end
        E_LD: begin
          o_idx   <= cb_rdata;
          o_found <= 1'b1;
          o_last  <= (NW'(j) + NW'(1) == n);
          o_ov    <= over;
          o_valid <= 1'b1;
          state   <= E_WAIT;
        end
        E_WAIT: begin
          if (response.ready) begin
            o_valid <= 1'b0;
            if (o_last) begin
              state <= IDLE;
            end else begin
              j     <= j + BW'(1);
              state <= E_RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Memories.
  // ---------------------------------------------------------------------------
  gcns_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_point_cell (
    .clk(clk), .we(pc_we), .waddr(pc_waddr), .wdata(pc_wdata),
    .raddr(pc_raddr), .rdata(pc_rdata)
  );

  gcns_ram #(.WIDTH(PCW), .DEPTH(MAX_CELLS + 1)) u_cell_start (
    .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
    .raddr(cs_raddr), .rdata(cs_rdata)
  );

  gcns_ram #(.WIDTH(PIW), .DEPTH(MAX_POINTS)) u_sorted_points (
    .clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
    .raddr(sp_raddr), .rdata(sp_rdata)
  );

  gcns_ram #(.WIDTH(gcns_pkg::NBR_W), .DEPTH(MAX_CANDIDATES)) u_cand_buf (
    .clk(clk), .we(cb_we), .waddr(cb_waddr), .wdata(cb_wdata),
    .raddr(cb_raddr), .rdata(cb_rdata)
  );

  gcns_mul u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .p(p)
  );

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_no_accept_while_output: assert property (@(posedge clk) disable iff (rst)
    response.valid |-> !request.ready)
    else $error("request accepted while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= PCW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_cand_bound: assert property (@(posedge clk) disable iff (rst)
    state != IDLE |-> n <= NW'(MAX_CANDIDATES))
    else $error("candidate count beyond limit");

  a_not_found_last: assert property (@(posedge clk) disable iff (rst)
    (response.valid && !response.found) |-> (response.last && !response.overflow))
    else $error("not-found result must be a lone last item");

endmodule
